// File: rtl/pls_pkg.sv
package pls_pkg;

	localparam int PLS_CAPACITY  = 256;
	localparam int FUNC_W        = 4;
	localparam int POS_W         = 9;
	localparam int DATA_W        = 32;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_COUNT_W = 9;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD_FIRST    = 4'd0,
		FN_ADD_LAST     = 4'd1,
		FN_ADD_AT       = 4'd2,
		FN_REMOVE_FIRST = 4'd3,
		FN_REMOVE_LAST  = 4'd4,
		FN_REMOVE_AT    = 4'd5,
		FN_GET_FIRST    = 4'd6,
		FN_GET_LAST     = 4'd7,
		FN_GET_AT       = 4'd8,
		FN_GET_MID      = 4'd9,
		FN_GET_SIZE     = 4'd10
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_EMPTY   = 2'd1,
		STS_BAD_POS = 2'd2,
		STS_FULL    = 2'd3
	} status_t;

	// request class
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_ADD  = 2'd1,
		CLS_REM  = 2'd2,
		CLS_GET  = 2'd3
	} req_class_t;

	// command broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_REMOVE = 3'd2,
		CELL_LOAD   = 3'd3,
		CELL_SHIFT  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		SM_IDLE = 2'b01,
		SM_SCAN = 2'b10
	} state_t;

endpackage

// File: rtl/pls_if.sv
interface pls_req_if import pls_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;

	modport source (output valid, output func, output position, output item_value,
		input ready);
	modport sink (input valid, input func, input position, input item_value,
		output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] read_value;
	logic [ENTRY_COUNT_W-1:0] entry_count;

	modport source (output valid, output status, output read_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input read_value, input entry_count,
		output ready);
endinterface

// File: rtl/pls_cell.sv
module pls_cell import pls_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IW    = 8
) (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic [IW-1:0]            pos,
	input  logic signed [DATA_W-1:0] left_entry,
	input  logic signed [DATA_W-1:0] right_entry,
	input  logic signed [DATA_W-1:0] right_tap,
	output logic signed [DATA_W-1:0] entry,
	output logic signed [DATA_W-1:0] tap
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] tap_q;

	// entry storage and read tap, no reset
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (MY_IDX > pos) begin
					entry_q <= left_entry;
				end else if (MY_IDX == pos) begin
					entry_q <= cmd.value;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					entry_q <= right_entry;
				end
			end
			CELL_LOAD:  tap_q <= entry_q;
			CELL_SHIFT: tap_q <= right_tap;
			default: ;
		endcase
	end

	assign entry = entry_q;
	assign tap   = tap_q;

endmodule

// File: rtl/positional_list_store.sv
// channel  role     payload                               item moves when
// req      sink     func, position, item_value            req.valid && req.ready
// rsp      source   status, read_value, entry_count       rsp.valid && rsp.ready
//
// add, remove, get_size and every refused request: result registered at the
// accept edge, visible in the next cycle; all cells shift together at that edge
// successful get at position k: cells copy entries into read taps at the accept
// edge; the tap chain moves the snapshot one cell toward cell 0 per cycle
// reset clears the entry count and control only; cell contents stay unknown
// req.ready drops while a read scans and while a result waits untaken
module positional_list_store import pls_pkg::*; #(
	parameter int CAPACITY = PLS_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	pls_req_if.sink   req,
	pls_rsp_if.source rsp
);

	// count width, cell index width, compare width
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	// control state
	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   scan_q;
	logic            rsp_vld_q;

	// result payload
	status_t                  rsp_status_q;
	logic signed [DATA_W-1:0] rsp_value_q;
	logic [ENTRY_COUNT_W-1:0] rsp_count_q;

	// decode
	req_class_t    cls;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [PW-1:0] last_w;
	logic [PW-1:0] tgt;
	status_t       sts;
	logic          do_ins;
	logic          do_rem;
	logic          do_get;
	logic          accept;
	logic [CW-1:0] cnt_nxt;

	// cell row
	cell_cmd_t                cmd;
	logic [IW-1:0]            cell_pos;
	logic signed [DATA_W-1:0] entry [CAPACITY];
	logic signed [DATA_W-1:0] tap   [CAPACITY];

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == SM_IDLE) && (!rsp_vld_q || rsp.ready);

	assign pos_w  = PW'(req.position);
	assign cnt_w  = PW'(cnt_q);
	assign last_w = (cnt_q == '0) ? '0 : cnt_w - PW'(1);

	// classify the request
	always_comb begin
		unique case (req.func) inside
			FN_ADD_FIRST, FN_ADD_LAST, FN_ADD_AT:          cls = CLS_ADD;
			FN_REMOVE_FIRST, FN_REMOVE_LAST, FN_REMOVE_AT: cls = CLS_REM;
			FN_GET_FIRST, FN_GET_LAST, FN_GET_AT, FN_GET_MID: cls = CLS_GET;
			default:                                       cls = CLS_NONE;
		endcase
	end

	// target position of the request
	always_comb begin
		unique case (req.func)
			FN_ADD_LAST:    tgt = cnt_w;
			FN_ADD_AT:      tgt = pos_w;
			FN_REMOVE_LAST: tgt = last_w;
			FN_REMOVE_AT:   tgt = pos_w;
			FN_GET_LAST:    tgt = last_w;
			FN_GET_AT:      tgt = pos_w;
			FN_GET_MID:     tgt = last_w >> 1;
			default:        tgt = '0;
		endcase
	end

	// status: position above count is checked before full on inserts,
	// empty before position on removes and reads
	always_comb begin
		sts    = STS_OK;
		do_ins = 1'b0;
		do_rem = 1'b0;
		do_get = 1'b0;
		case (cls)
			CLS_ADD: begin
				if (tgt > cnt_w) begin
					sts = STS_BAD_POS;
				end else if (cnt_w >= PW'(CAPACITY)) begin
					sts = STS_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			CLS_REM, CLS_GET: begin
				if (cnt_q == '0) begin
					sts = STS_EMPTY;
				end else if (tgt >= cnt_w) begin
					sts = STS_BAD_POS;
				end else begin
					do_rem = (cls == CLS_REM);
					do_get = (cls == CLS_GET);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (do_ins) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (do_rem) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end

	// command to the cell row: at most one shift of the whole row per cycle
	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.value = req.item_value;
		cell_pos  = tgt[IW-1:0];
		if (accept && do_ins) begin
			cmd.op = CELL_INSERT;
		end else if (accept && do_rem) begin
			cmd.op = CELL_REMOVE;
		end else if (accept && do_get) begin
			cmd.op = CELL_LOAD;
		end else if (state_q == SM_SCAN && scan_q != '0) begin
			cmd.op = CELL_SHIFT;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_entry;
		logic signed [DATA_W-1:0] right_entry;
		logic signed [DATA_W-1:0] right_tap;

		if (i == 0) begin : g_first
			assign left_entry = req.item_value;
		end else begin : g_mid
			assign left_entry = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			// top cell keeps its own entry on remove, nothing past it is read
			assign right_entry = entry[i];
			assign right_tap   = '0;
		end else begin : g_inner
			assign right_entry = entry[i+1];
			assign right_tap   = tap[i+1];
		end

		pls_cell #(
			.INDEX (i),
			.IW    (IW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.pos         (cell_pos),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.right_tap   (right_tap),
			.entry       (entry[i]),
			.tap         (tap[i])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SM_IDLE;
			cnt_q     <= '0;
			scan_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				SM_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_nxt;
						if (do_get) begin
							// read waits for the tap chain
							state_q   <= SM_SCAN;
							scan_q    <= tgt[IW-1:0];
							rsp_vld_q <= 1'b0;
						end else begin
							rsp_vld_q <= 1'b1;
						end
					end else if (rsp.ready) begin
						rsp_vld_q <= 1'b0;
					end
				end
				SM_SCAN: begin
					if (scan_q == '0) begin
						state_q   <= SM_IDLE;
						rsp_vld_q <= 1'b1;
					end else begin
						scan_q <= scan_q - IW'(1);
					end
				end
				default: state_q <= SM_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == SM_IDLE && accept && !do_get) begin
			rsp_status_q <= sts;
			rsp_value_q  <= '0;
			rsp_count_q  <= ENTRY_COUNT_W'(cnt_nxt);
		end else if (state_q == SM_SCAN && scan_q == '0) begin
			rsp_status_q <= STS_OK;
			rsp_value_q  <= tap[0];
			rsp_count_q  <= ENTRY_COUNT_W'(cnt_q);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.entry_count = rsp_count_q;

	// count never passes capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// a successful insert grows the list by exactly one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_ins |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the count");

	// no request taken and no result shown while a read scans
	a_scan_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SM_SCAN |-> !req.ready && !rsp_vld_q)
		else $error("request taken during read scan");

	// a shown result carries the current count
	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q |-> rsp_count_q == ENTRY_COUNT_W'(cnt_q))
		else $error("result count differs from held count");

endmodule
